// ===== rtl/core/cuwa_pkg.sv =====
// ----------------------------------------------------------------------------
// cuwa_pkg
// Shared constants, types and state encodings for the cpu utilisation
// window average block.
// ----------------------------------------------------------------------------
package cuwa_pkg;

  localparam int MAX_CPUS   = 64;
  localparam int MAX_WINDOW = 16;

  localparam int CPU_W    = $clog2(MAX_CPUS);
  localparam int SLOT_W   = $clog2(MAX_WINDOW);
  localparam int WIN_W    = 5;
  localparam int IDLE_W   = 64;
  localparam int UTIL_W   = 14;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 16;
  localparam int DELTA_W  = 20;
  localparam int SUM_W    = 18;
  localparam int PROD_W   = 37;
  localparam int NUM_W    = 38;
  localparam int LIM_W    = 31;
  localparam int QUO_W    = 14;
  localparam int DVD_W    = 31;
  localparam int DVS_W    = 17;
  localparam int SD_W     = DVS_W + QUO_W - 1;
  localparam int DCNT_W   = 4;
  localparam int RING_AW  = CPU_W + SLOT_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [UTIL_W-1:0]   FULL_SCALE   = 14'd10000;
  localparam logic [16:0]         TICK_SCALE   = 17'd100000;
  localparam logic [14:0]         LIMIT_SCALE  = 15'd20000;
  localparam logic [WIN_W-1:0]    WIN_MAX      = 5'd16;
  localparam logic [WIN_W-1:0]    WIN_RESET    = 5'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  // register indexes of the configuration port
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  typedef struct packed {
    logic [CPU_W-1:0]   cpu;
    logic [DELTA_W-1:0] delta;
    logic               big;
    logic [SLOT_W-1:0]  pos;
    logic [WIN_W-1:0]   n;
    logic               first;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic {
    F_IDLE,
    F_CALC
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MULQ,
    B_MULL,
    B_CHK,
    B_DIV1,
    B_WRITE,
    B_SUM,
    B_DIV2,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/core/cuwa_div.sv =====
// ----------------------------------------------------------------------------
// cuwa_div
// Restoring divider, one quotient bit per cycle, 14-bit quotient. The
// dividend must stay below divisor * 2^14.
// ----------------------------------------------------------------------------
module cuwa_div (
  input  logic               clk,
  input  logic               rst,
  input  cuwa_pkg::div_req_t req,
  output cuwa_pkg::div_rsp_t rsp
);

  logic [cuwa_pkg::DVD_W-1:0]  rem;
  logic [cuwa_pkg::SD_W-1:0]   sd;
  logic [cuwa_pkg::QUO_W-1:0]  quo;
  logic [cuwa_pkg::DCNT_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic                        ge;

  assign ge = rem >= {1'b0, sd};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      sd  <= {req.divisor, {(cuwa_pkg::QUO_W-1){1'b0}}};
      quo <= '0;
      cnt <= cuwa_pkg::DCNT_W'(cuwa_pkg::QUO_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - {1'b0, sd};
      end
      quo <= {quo[cuwa_pkg::QUO_W-2:0], ge};
      sd  <= sd >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/core/cuwa_front.sv =====
// ----------------------------------------------------------------------------
// cuwa_front
// Accepts samples, forms the idle delta against the stored count per cpu and
// tracks the shared ring position and fill count.
// ----------------------------------------------------------------------------
module cuwa_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [cuwa_pkg::CPU_W-1:0]    cpu_index,
  input  logic [cuwa_pkg::IDLE_W-1:0]   idle_ticks,
  input  logic                          round_end,
  input  logic [cuwa_pkg::WIN_W-1:0]    window_length,
  output cuwa_pkg::job_t                job,
  output logic                          push,
  input  logic                          full
);

  cuwa_pkg::front_state_t state, state_next;

  logic [cuwa_pkg::IDLE_W-1:0] prev_mem [cuwa_pkg::MAX_CPUS];
  logic [cuwa_pkg::IDLE_W-1:0] prev_rd;
  logic [cuwa_pkg::MAX_CPUS-1:0] seen;

  logic [cuwa_pkg::CPU_W-1:0]  cpu_r;
  logic [cuwa_pkg::IDLE_W-1:0] idle_r;
  logic                        last_r;

  logic [cuwa_pkg::SLOT_W-1:0] ring_position, ring_position_next;
  logic [cuwa_pkg::WIN_W-1:0]  fill_count, fill_count_next;

  logic [cuwa_pkg::WIN_W-1:0]  n_win;
  logic [cuwa_pkg::SLOT_W-1:0] pos;
  logic [cuwa_pkg::WIN_W-1:0]  pos_inc;
  logic [cuwa_pkg::IDLE_W-1:0] prev;
  logic [cuwa_pkg::IDLE_W-1:0] delta;
  logic                        accept;

  assign accept = item_valid && !item_stall;

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (window_length == '0) begin
      n_win = cuwa_pkg::WIN_W'(1);
    end else if (window_length > cuwa_pkg::WIN_MAX) begin
      n_win = cuwa_pkg::WIN_MAX;
    end else begin
      n_win = window_length;
    end
  end

  always_comb begin
    pos     = ({1'b0, ring_position} >= n_win) ? '0 : ring_position;
    pos_inc = {1'b0, pos} + 1'b1;
    prev    = seen[cpu_r] ? prev_rd : '0;
    delta   = idle_r - prev;
  end

  always_comb begin
    job.cpu   = cpu_r;
    job.delta = delta[cuwa_pkg::DELTA_W-1:0];
    job.big   = |delta[cuwa_pkg::IDLE_W-1:cuwa_pkg::DELTA_W];
    job.pos   = pos;
    job.n     = (fill_count < n_win) ? fill_count : n_win;
    job.first = (fill_count == '0);
  end

  always_comb begin
    ring_position_next = ring_position;
    fill_count_next    = fill_count;
    if (last_r) begin
      if (fill_count != '0) begin
        ring_position_next = (pos_inc >= n_win) ? '0 : pos_inc[cuwa_pkg::SLOT_W-1:0];
      end
      fill_count_next = (fill_count < n_win) ? fill_count + 1'b1 : n_win;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cuwa_pkg::F_IDLE: begin
        if (item_valid) state_next = cuwa_pkg::F_CALC;
      end
      cuwa_pkg::F_CALC: begin
        if (!full) state_next = cuwa_pkg::F_IDLE;
      end
      default: state_next = cuwa_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_stall = 1'b1;
    push       = 1'b0;
    case (state)
      cuwa_pkg::F_IDLE: item_stall = 1'b0;
      cuwa_pkg::F_CALC: push = !full;
      default: begin
        item_stall = 1'b1;
        push       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cuwa_pkg::F_IDLE;
      seen          <= '0;
      ring_position <= '0;
      fill_count    <= '0;
    end else begin
      state <= state_next;
      if (push) begin
        seen[cpu_r]   <= 1'b1;
        ring_position <= ring_position_next;
        fill_count    <= fill_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cpu_r   <= cpu_index;
      idle_r  <= idle_ticks;
      last_r  <= round_end;
      prev_rd <= prev_mem[cpu_index];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      prev_mem[cpu_r] <= idle_r;
    end
  end

endmodule

// ===== rtl/core/cuwa_queue.sv =====
// ----------------------------------------------------------------------------
// cuwa_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module cuwa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cuwa_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output cuwa_pkg::job_t pop_job
);

  cuwa_pkg::job_t              slots [cuwa_pkg::QUEUE_DEPTH];
  logic [cuwa_pkg::QPTR_W-1:0] wr_ptr;
  logic [cuwa_pkg::QPTR_W-1:0] rd_ptr;
  logic [cuwa_pkg::QCNT_W-1:0] count;

  assign full    = (count == cuwa_pkg::QCNT_W'(cuwa_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

// ===== rtl/core/cuwa_back.sv =====
// ----------------------------------------------------------------------------
// cuwa_back
// Turns a job into the current utilisation, stores it in the cpu's ring and,
// once a round has ended, sums the window slot by slot into a rounded mean.
// ----------------------------------------------------------------------------
module cuwa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  cuwa_pkg::job_t                job,
  output logic                          pop,
  input  logic [cuwa_pkg::PERIOD_W-1:0] period_ms,
  output cuwa_pkg::div_req_t            div_req,
  input  cuwa_pkg::div_rsp_t            div_rsp,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [cuwa_pkg::UTIL_W-1:0]   utilization,
  output logic [cuwa_pkg::UTIL_W-1:0]   average,
  output logic                          average_valid
);

  cuwa_pkg::back_state_t state, state_next;

  logic [cuwa_pkg::UTIL_W-1:0] ring [1 << cuwa_pkg::RING_AW];
  logic [cuwa_pkg::UTIL_W-1:0] ring_rd;

  cuwa_pkg::job_t                job_r;
  logic [cuwa_pkg::PERIOD_W-1:0] p_eff;
  logic [cuwa_pkg::PROD_W-1:0]   prod;
  logic [cuwa_pkg::NUM_W-1:0]    num;
  logic [cuwa_pkg::LIM_W-1:0]    lim;
  logic                          saturate;
  logic [cuwa_pkg::UTIL_W-1:0]   util_r;
  logic [cuwa_pkg::UTIL_W-1:0]   avg_r;
  logic                          avg_valid_r;
  logic [cuwa_pkg::WIN_W-1:0]    j;
  logic                          pend;
  logic [cuwa_pkg::SUM_W-1:0]    sum;
  logic                          sum_done;
  logic [cuwa_pkg::SUM_W:0]      avg_num;
  logic                          load;

  assign p_eff    = (period_ms == '0) ? cuwa_pkg::PERIOD_W'(1) : period_ms;
  assign saturate = job_r.big || (num >= {{(cuwa_pkg::NUM_W-cuwa_pkg::LIM_W){1'b0}}, lim});
  assign sum_done = (j == job_r.n) && !pend;
  assign avg_num  = {sum, 1'b0} + {{(cuwa_pkg::SUM_W+1-cuwa_pkg::WIN_W){1'b0}}, job_r.n};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cuwa_pkg::B_IDLE:  if (job_valid) state_next = cuwa_pkg::B_MULQ;
      cuwa_pkg::B_MULQ:  state_next = cuwa_pkg::B_MULL;
      cuwa_pkg::B_MULL:  state_next = cuwa_pkg::B_CHK;
      cuwa_pkg::B_CHK:   state_next = saturate ? cuwa_pkg::B_WRITE : cuwa_pkg::B_DIV1;
      cuwa_pkg::B_DIV1:  if (div_rsp.done) state_next = cuwa_pkg::B_WRITE;
      cuwa_pkg::B_WRITE: state_next = job_r.first ? cuwa_pkg::B_DONE : cuwa_pkg::B_SUM;
      cuwa_pkg::B_SUM:   if (sum_done) state_next = cuwa_pkg::B_DIV2;
      cuwa_pkg::B_DIV2:  if (div_rsp.done) state_next = cuwa_pkg::B_DONE;
      cuwa_pkg::B_DONE:  if (!result_valid || !result_stall) state_next = cuwa_pkg::B_IDLE;
      default:           state_next = cuwa_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop              = 1'b0;
    load             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num[cuwa_pkg::DVD_W-1:0];
    div_req.divisor  = {p_eff, 1'b0};
    case (state)
      cuwa_pkg::B_IDLE: pop = job_valid;
      cuwa_pkg::B_CHK:  div_req.start = !saturate;
      cuwa_pkg::B_SUM: begin
        div_req.start    = sum_done;
        div_req.dividend = {{(cuwa_pkg::DVD_W-cuwa_pkg::SUM_W-1){1'b0}}, avg_num};
        div_req.divisor  = {{(cuwa_pkg::DVS_W-cuwa_pkg::WIN_W-1){1'b0}}, job_r.n, 1'b0};
      end
      cuwa_pkg::B_DONE: load = !result_valid || !result_stall;
      default: begin
        pop           = 1'b0;
        load          = 1'b0;
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cuwa_pkg::B_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cuwa_pkg::B_IDLE: begin
        if (job_valid) job_r <= job;
      end
      cuwa_pkg::B_MULQ: prod <= job_r.delta * cuwa_pkg::TICK_SCALE;
      cuwa_pkg::B_MULL: begin
        // 2q + p - 1 against 2p * 10000 tells whether the quotient saturates
        num <= {prod, 1'b0} + {{(cuwa_pkg::NUM_W-cuwa_pkg::PERIOD_W){1'b0}}, p_eff}
               - cuwa_pkg::NUM_W'(1);
        lim <= p_eff * cuwa_pkg::LIMIT_SCALE;
      end
      cuwa_pkg::B_CHK: begin
        if (saturate) util_r <= '0;
      end
      cuwa_pkg::B_DIV1: begin
        if (div_rsp.done) util_r <= cuwa_pkg::FULL_SCALE - div_rsp.quotient;
      end
      cuwa_pkg::B_WRITE: begin
        j    <= '0;
        pend <= 1'b0;
        sum  <= '0;
        if (job_r.first) begin
          avg_r       <= '0;
          avg_valid_r <= 1'b0;
        end
      end
      cuwa_pkg::B_SUM: begin
        // read data is registered, so pend marks an address whose data is still due
        if (j != job_r.n) begin
          j    <= j + 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (pend) sum <= sum + {{(cuwa_pkg::SUM_W-cuwa_pkg::UTIL_W){1'b0}}, ring_rd};
      end
      cuwa_pkg::B_DIV2: begin
        if (div_rsp.done) begin
          avg_r <= (div_rsp.quotient > cuwa_pkg::FULL_SCALE) ? cuwa_pkg::FULL_SCALE
                                                            : div_rsp.quotient;
          avg_valid_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == cuwa_pkg::B_WRITE) begin
      ring[{job_r.cpu, job_r.pos}] <= util_r;
    end
    if (state == cuwa_pkg::B_SUM) begin
      ring_rd <= ring[{job_r.cpu, j[cuwa_pkg::SLOT_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      utilization   <= util_r;
      average       <= avg_r;
      average_valid <= avg_valid_r;
    end
  end

endmodule

// ===== rtl/core/cpu_utilization_window_average.sv =====
// ----------------------------------------------------------------------------
// cpu_utilization_window_average
// Per-cpu utilisation from cumulative idle counts, with a moving window mean.
// ----------------------------------------------------------------------------
// One sample (cpu_index, idle_ticks, round_end) is taken per transfer on the
// item channel; one result (utilization, average, average_valid) leaves per
// sample on the result channel, in order. window_length and period_ms are
// written through cfg_write/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// The front stalls after each transfer to read the stored count, then hands
// the job to a two-entry queue once it has room. The back runs the restoring
// divider for the utilisation, writes the cpu ring, reads back n slots (n up
// to 16) and runs the divider again for the mean; a saturated utilisation
// skips the first division, and a first-round sample skips the window sum
// and the second division. The back takes a new job only once the last one
// is through, so the divider and the single-port ring set the throughput.
// Reset (rst, synchronous) clears the per-cpu valid flags of the stored
// counts, the fill count and the ring position; no clearing pass is needed.
// While the receiver holds result_stall the result register holds, the back
// waits, and the queue fills before item_stall rises for new samples.
// ----------------------------------------------------------------------------
module cpu_utilization_window_average (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [cuwa_pkg::CPU_W-1:0]    cpu_index,
  input  logic [cuwa_pkg::IDLE_W-1:0]   idle_ticks,
  input  logic                          round_end,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [cuwa_pkg::UTIL_W-1:0]   utilization,
  output logic [cuwa_pkg::UTIL_W-1:0]   average,
  output logic                          average_valid,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [cuwa_pkg::CFG_W-1:0]    cfg_data
);

  logic [cuwa_pkg::WIN_W-1:0]    window_length;
  logic [cuwa_pkg::PERIOD_W-1:0] period_ms;

  cuwa_pkg::job_t     push_job;
  cuwa_pkg::job_t     pop_job;
  logic               push;
  logic               full;
  logic               pop;
  logic               job_valid;
  cuwa_pkg::div_req_t div_req;
  cuwa_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= cuwa_pkg::WIN_RESET;
      period_ms     <= cuwa_pkg::PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cuwa_pkg::CFG_WINDOW: window_length <= cfg_data[cuwa_pkg::WIN_W-1:0];
        cuwa_pkg::CFG_PERIOD: period_ms     <= cfg_data[cuwa_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cuwa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cpu_index     (cpu_index),
    .idle_ticks    (idle_ticks),
    .round_end     (round_end),
    .window_length (window_length),
    .job           (push_job),
    .push          (push),
    .full          (full)
  );

  cuwa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .valid    (job_valid),
    .pop_job  (pop_job)
  );

  cuwa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cuwa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job           (pop_job),
    .pop           (pop),
    .period_ms     (period_ms),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .utilization   (utilization),
    .average       (average),
    .average_valid (average_valid)
  );

endmodule
